>>> rtl/wrpt_pkg.sv
// Package for the work/rest phase timer: types, codes, constants and duration conversion.
`default_nettype none
package wrpt_pkg;

  localparam logic [31:0] CHECK_INTERVAL_MS = 32'd1000;
  localparam logic [15:0] MS_PER_MIN        = 16'd60000;
  localparam logic [30:0] MS_SAT            = 31'h7FFF_FFFF;
  localparam logic [30:0] WORK_MS_RESET     = 31'd1500000;
  localparam logic [30:0] REST_MS_RESET     = 31'd300000;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = 16;

  typedef enum logic [2:0] {
    REQ_START  = 3'd0,
    REQ_PAUSE  = 3'd1,
    REQ_RESUME = 3'd2,
    REQ_FORCE  = 3'd3,
    REQ_STOP   = 3'd4,
    REQ_CHECK  = 3'd5,
    REQ_STATUS = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    REM_NONE      = 2'd0,
    REM_WORK_DONE = 2'd1,
    REM_REST_DONE = 2'd2,
    REM_FORCED    = 2'd3
  } rem_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORK_MINUTES = 1'b0,
    CFG_REST_MINUTES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] now_ms;
    logic        reminder_accepted;
  } req_item_t;

  typedef struct packed {
    logic        timer_active;
    logic        timer_paused;
    logic        rest_phase;
    logic [30:0] time_left;
    logic [1:0]  reminder_code;
    logic        wake_schedule;
    logic        wake_cancel;
    logic [30:0] wake_delay_ms;
  } rsp_item_t;

  typedef struct packed {
    logic [30:0] work_ms;
    logic [30:0] rest_ms;
  } dur_t;

  function automatic logic [30:0] minutes_to_ms(input logic [15:0] minutes);
    logic [31:0] prod;
    prod = {16'd0, minutes} * {16'd0, MS_PER_MIN};
    return prod[31] ? MS_SAT : prod[30:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/wrpt_if.sv
// Request and result channel interfaces of the phase timer.
`default_nettype none
interface wrpt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] now_ms;
  logic        reminder_accepted;

  modport source (output valid, output req_type, output now_ms, output reminder_accepted,
                  input ready);
  modport sink (input valid, input req_type, input now_ms, input reminder_accepted,
                output ready);
endinterface

interface wrpt_rsp_if;
  logic        valid;
  logic        ready;
  logic        timer_active;
  logic        timer_paused;
  logic        rest_phase;
  logic [30:0] time_left;
  logic [1:0]  reminder_code;
  logic        wake_schedule;
  logic        wake_cancel;
  logic [30:0] wake_delay_ms;

  modport source (output valid, output timer_active, output timer_paused, output rest_phase,
                  output time_left, output reminder_code, output wake_schedule,
                  output wake_cancel, output wake_delay_ms, input ready);
  modport sink (input valid, input timer_active, input timer_paused, input rest_phase,
                input time_left, input reminder_code, input wake_schedule,
                input wake_cancel, input wake_delay_ms, output ready);
endinterface
`default_nettype wire

>>> rtl/work_rest_phase_timer_core.sv
// Top level of the work/rest phase timer: request register, update stage, result register.
// An accepted request is held in the request register, its result then in the result
// register; a request waits there while the result side holds off.
// Throughput: one request per cycle while results are taken; the update is a single pass.
// Reset (rst, synchronous): timer idle, deadline and check time zero, no requests held,
// presets back to 25 minutes work and 5 minutes rest.
`default_nettype none
module work_rest_phase_timer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [wrpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wrpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  wrpt_req_if.sink                             req,
  wrpt_rsp_if.source                           rsp
);

  wrpt_pkg::dur_t      dur;
  wrpt_pkg::req_item_t stage;
  logic                stage_valid;
  wrpt_pkg::rsp_item_t result;
  wrpt_pkg::rsp_item_t out_item;
  logic                out_valid;
  logic                fire;

  assign fire      = stage_valid && (!out_valid || rsp.ready);
  assign req.ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      stage.req_type          <= req.req_type;
      stage.now_ms            <= req.now_ms;
      stage.reminder_accepted <= req.reminder_accepted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

  wrpt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dur       (dur)
  );

  wrpt_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (stage),
    .dur    (dur),
    .result (result)
  );

  assign rsp.valid         = out_valid;
  assign rsp.timer_active  = out_item.timer_active;
  assign rsp.timer_paused  = out_item.timer_paused;
  assign rsp.rest_phase    = out_item.rest_phase;
  assign rsp.time_left     = out_item.time_left;
  assign rsp.reminder_code = out_item.reminder_code;
  assign rsp.wake_schedule = out_item.wake_schedule;
  assign rsp.wake_cancel   = out_item.wake_cancel;
  assign rsp.wake_delay_ms = out_item.wake_delay_ms;

endmodule
`default_nettype wire

>>> rtl/wrpt_cfg.sv
// Preset registers, held as phase lengths in milliseconds.
`default_nettype none
module wrpt_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [wrpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wrpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output wrpt_pkg::dur_t                      dur
);

  logic [30:0] work_ms;
  logic [30:0] rest_ms;
  logic [30:0] wdata_ms;

  assign wdata_ms = wrpt_pkg::minutes_to_ms(cfg_wdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      work_ms <= wrpt_pkg::WORK_MS_RESET;
      rest_ms <= wrpt_pkg::REST_MS_RESET;
    end else if (cfg_we) begin
      unique case (wrpt_pkg::cfg_idx_t'(cfg_index))
        wrpt_pkg::CFG_WORK_MINUTES: work_ms <= wdata_ms;
        wrpt_pkg::CFG_REST_MINUTES: rest_ms <= wdata_ms;
        default: ;
      endcase
    end
  end

  assign dur.work_ms = work_ms;
  assign dur.rest_ms = rest_ms;

endmodule
`default_nettype wire

>>> rtl/wrpt_step.sv
// Timer state and the per-request update with its result.
`default_nettype none
module wrpt_step (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire wrpt_pkg::req_item_t item,
  input  wire wrpt_pkg::dur_t      dur,
  output wrpt_pkg::rsp_item_t      result
);

  logic        running, running_next;
  logic        frozen, frozen_next;
  logic        in_rest, in_rest_next;
  logic [31:0] deadline, deadline_next;
  logic [30:0] frozen_rem, frozen_rem_next;
  logic [31:0] last_check, last_check_next;
  logic [30:0] latched_rest_ms, latched_rest_ms_next;

  logic [31:0] since_deadline;
  logic [31:0] to_deadline;
  logic [31:0] since_check;
  logic        reached;
  logic [30:0] rem_run;
  logic        rearm;
  logic [30:0] arm_ms;
  logic [1:0]  code;
  logic        sched;
  logic        cancel;
  logic [30:0] delay;
  logic [30:0] remaining;

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      frozen          <= 1'b0;
      in_rest         <= 1'b0;
      deadline        <= 32'd0;
      frozen_rem      <= 31'd0;
      last_check      <= 32'd0;
      latched_rest_ms <= 31'd0;
    end else if (fire) begin
      running         <= running_next;
      frozen          <= frozen_next;
      in_rest         <= in_rest_next;
      deadline        <= deadline_next;
      frozen_rem      <= frozen_rem_next;
      last_check      <= last_check_next;
      latched_rest_ms <= latched_rest_ms_next;
    end
  end

  assign since_deadline = item.now_ms - deadline;
  assign to_deadline    = deadline - item.now_ms;
  assign since_check    = item.now_ms - last_check;
  assign reached        = ~since_deadline[31];
  assign rem_run        = reached ? 31'd0 : to_deadline[30:0];

  always_comb begin
    running_next         = running;
    frozen_next          = frozen;
    in_rest_next         = in_rest;
    frozen_rem_next      = frozen_rem;
    last_check_next      = last_check;
    latched_rest_ms_next = latched_rest_ms;
    rearm                = 1'b0;
    arm_ms               = 31'd0;
    code                 = wrpt_pkg::REM_NONE;
    sched                = 1'b0;
    cancel               = 1'b0;
    delay                = 31'd0;

    unique case (wrpt_pkg::req_t'(item.req_type))
      wrpt_pkg::REQ_START: begin
        latched_rest_ms_next = dur.rest_ms;
        running_next         = 1'b1;
        frozen_next          = 1'b0;
        in_rest_next         = 1'b0;
        frozen_rem_next      = 31'd0;
        rearm                = 1'b1;
        arm_ms               = dur.work_ms;
      end
      wrpt_pkg::REQ_PAUSE: begin
        if (running && !frozen) begin
          frozen_rem_next = rem_run;
          frozen_next     = 1'b1;
          cancel          = 1'b1;
        end
      end
      wrpt_pkg::REQ_RESUME: begin
        if (running && frozen) begin
          frozen_next     = 1'b0;
          frozen_rem_next = 31'd0;
          rearm           = 1'b1;
          arm_ms          = frozen_rem;
        end
      end
      wrpt_pkg::REQ_FORCE: begin
        if (running) begin
          in_rest_next    = 1'b1;
          frozen_next     = 1'b0;
          frozen_rem_next = 31'd0;
          rearm           = 1'b1;
          arm_ms          = latched_rest_ms;
          code            = wrpt_pkg::REM_FORCED;
        end
      end
      wrpt_pkg::REQ_STOP: begin
        running_next    = 1'b0;
        frozen_next     = 1'b0;
        in_rest_next    = 1'b0;
        frozen_rem_next = 31'd0;
        cancel          = 1'b1;
      end
      wrpt_pkg::REQ_CHECK: begin
        if (since_check >= wrpt_pkg::CHECK_INTERVAL_MS) begin
          last_check_next = item.now_ms;
          if (running && !frozen && reached && item.reminder_accepted) begin
            cancel = 1'b1;
            if (!in_rest) begin
              in_rest_next    = 1'b1;
              frozen_next     = 1'b1;
              frozen_rem_next = latched_rest_ms;
              code            = wrpt_pkg::REM_WORK_DONE;
            end else begin
              running_next    = 1'b0;
              frozen_next     = 1'b0;
              in_rest_next    = 1'b0;
              frozen_rem_next = 31'd0;
              code            = wrpt_pkg::REM_REST_DONE;
            end
          end
        end
      end
      default: ;
    endcase

    if (rearm) begin
      sched = 1'b1;
      delay = arm_ms;
    end
    deadline_next = rearm ? (item.now_ms + {1'b0, arm_ms}) : deadline;

    // a fresh deadline lies arm_ms ahead, at most 2^31-1
    if (!running_next) begin
      remaining = 31'd0;
    end else if (frozen_next) begin
      remaining = frozen_rem_next;
    end else if (rearm) begin
      remaining = arm_ms;
    end else begin
      remaining = rem_run;
    end

    result.timer_active  = running_next;
    result.timer_paused  = frozen_next;
    result.rest_phase    = in_rest_next;
    result.time_left     = remaining;
    result.reminder_code = code;
    result.wake_schedule = sched;
    result.wake_cancel   = cancel;
    result.wake_delay_ms = delay;
  end

endmodule
`default_nettype wire
